[rtl/cpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    localparam int CPR_FRAC_BITS    = 16;
    localparam int CPR_CORDIC_STEPS = 32;
    localparam int CPR_SQRT_STEPS   = 32;
    localparam int CPR_DIV_STEPS    = 32;

    // Register stages of each unit, from its input registers to its result.
    localparam int CPR_CORDIC_LAT = CPR_CORDIC_STEPS + 2;
    localparam int CPR_RADIAL_LAT = CPR_SQRT_STEPS + CPR_DIV_STEPS + 2;
    localparam int CPR_PIPE_DEPTH = 2 + CPR_RADIAL_LAT;

    localparam logic [15:0] CPR_MIN_MAG_RST = 16'd7;

    localparam longint CPR_PI_Q30      = 64'sd3373259426;
    localparam longint CPR_HALF_PI_Q30 = 64'sd1686629713;

    // Arctangent of 2^-i in Q2.30.
    localparam logic [31:0] CPR_ATAN [CPR_CORDIC_STEPS] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // Pi rounded half up to the given number of fraction bits.
    function automatic longint cpr_pi_lim(input int frac);
        return (CPR_PI_Q30 + (longint'(1) << (29 - frac))) >>> (30 - frac);
    endfunction

endpackage

`default_nettype wire

[rtl/cartesian_to_polar_radar_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Radar measurement prediction: a tracked state (position and velocity in
// signed fixed point) goes in on the input channel, and range, bearing and
// range rate come out on the output channel, one result for each request.
// Both channels use valid and ready; min_magnitude is written through the
// configuration channel, which is always ready, and should only be written
// while no request is in flight.
// A request is accepted every cycle unless the output stalls. The radial path,
// the 32-stage square root followed by the 32-stage restoring divider, is the
// longest; the 32-step CORDIC runs alongside them.
// The whole pipeline advances together with the output register: while a
// result waits and the receiver holds ready low, every stage holds and the
// input ready drops, so nothing is lost or repeated.
// Reset clears all valid bits, including the output valid, and sets min_magnitude to 7.
module cartesian_to_polar_radar_unit
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = CPR_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [31:0]          i_pos_x,
    input  wire logic signed [31:0]          i_pos_y,
    input  wire logic signed [31:0]          i_vel_x,
    input  wire logic signed [31:0]          i_vel_y,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [15:0]                 i_min_magnitude,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [31:0]                      o_range,
    output logic signed [FRAC_BITS+2:0]      o_bearing,
    output logic signed [31:0]               o_range_rate
);

    localparam int BW      = FRAC_BITS + 3;
    localparam int BRG_DLY = CPR_PIPE_DEPTH - 1 - CPR_CORDIC_LAT;
    localparam logic signed [BW-1:0] BRG_LIM = BW'(cpr_pi_lim(FRAC_BITS));

    logic                  w_adv;
    logic [15:0]           r_min;
    logic [CPR_PIPE_DEPTH-1:0] r_vld;

    logic [31:0]           w_ax_in;
    logic signed [31:0]    w_x_in;
    logic signed [31:0]    r_x;
    logic signed [31:0]    r_y;
    logic signed [31:0]    r_vx;
    logic signed [31:0]    r_vy;

    logic [31:0]           w_ax;
    logic [31:0]           w_ay;
    logic [31:0]           w_avx;
    logic [31:0]           w_avy;
    logic [63:0]           r_sq_x;
    logic [63:0]           r_sq_y;
    logic [63:0]           r_p1;
    logic [63:0]           r_p2;
    logic                  r_n1;
    logic                  r_n2;

    logic signed [BW-1:0]  w_brg;
    logic signed [BW-1:0]  r_brg_dly [BRG_DLY];
    logic [31:0]           w_range;
    logic signed [31:0]    w_rate;

    logic                  r_out_valid;
    logic [31:0]           r_range;
    logic signed [BW-1:0]  r_bearing;
    logic signed [31:0]    r_rate;

    assign w_adv       = !r_out_valid || i_ready;
    assign o_ready     = w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= CPR_MIN_MAG_RST;
        end else if (i_cfg_valid) begin
            r_min <= i_min_magnitude;
        end
    end

    // A tiny x is replaced by the positive floor before anything else.
    assign w_ax_in = i_pos_x[31] ? 32'(-i_pos_x) : i_pos_x;
    assign w_x_in  = (w_ax_in < {16'd0, r_min}) ? $signed({16'd0, r_min}) : i_pos_x;

    assign w_ax  = r_x[31]  ? 32'(-r_x)  : r_x;
    assign w_ay  = r_y[31]  ? 32'(-r_y)  : r_y;
    assign w_avx = r_vx[31] ? 32'(-r_vx) : r_vx;
    assign w_avy = r_vy[31] ? 32'(-r_vy) : r_vy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x    <= w_x_in;
            r_y    <= i_pos_y;
            r_vx   <= i_vel_x;
            r_vy   <= i_vel_y;
            r_sq_x <= 64'(w_ax) * 64'(w_ax);
            r_sq_y <= 64'(w_ay) * 64'(w_ay);
            r_p1   <= 64'(w_ax) * 64'(w_avx);
            r_p2   <= 64'(w_ay) * 64'(w_avy);
            r_n1   <= r_x[31] ^ r_vx[31];
            r_n2   <= r_y[31] ^ r_vy[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[CPR_PIPE_DEPTH-2:0], i_valid};
        end
    end

    cpr_cordic #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_x       (r_x),
        .i_y       (r_y),
        .o_bearing (w_brg)
    );

    cpr_radial u_radial (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_sq_x       (r_sq_x),
        .i_sq_y       (r_sq_y),
        .i_p1         (r_p1),
        .i_p2         (r_p2),
        .i_n1         (r_n1),
        .i_n2         (r_n2),
        .i_min        (r_min),
        .o_range      (w_range),
        .o_range_rate (w_rate)
    );

    // The bearing is ready well before the divider finishes.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_brg_dly[0] <= w_brg;
            for (int k = 1; k < BRG_DLY; k++) begin
                r_brg_dly[k] <= r_brg_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[CPR_PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_range   <= w_range;
            r_bearing <= r_brg_dly[BRG_DLY-1];
            r_rate    <= w_rate;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_range      = r_range;
    assign o_bearing    = r_bearing;
    assign o_range_rate = r_rate;

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_range == '0)) |-> ((o_range_rate == '0) && (o_bearing == '0)))
        else $error("zero range without zero bearing and range rate");

    a_bearing_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_bearing <= BRG_LIM) && (o_bearing >= -BRG_LIM)))
        else $error("bearing outside plus or minus pi");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_result_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[CPR_PIPE_DEPTH-1] && o_ready) |=> o_valid)
        else $error("finished request did not reach the output register");

endmodule

`default_nettype wire

[rtl/cpr_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpr_cordic
    import cpr_pkg::*;
#(
    parameter int FRAC_BITS = CPR_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [31:0]            i_x,
    input  wire logic signed [31:0]            i_y,
    output logic signed      [FRAC_BITS+2:0]   o_bearing
);

    localparam int XW = 35;
    localparam int ZW = 34;
    localparam int BW = FRAC_BITS + 3;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] LIM = ZW'(cpr_pi_lim(FRAC_BITS));

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cordic_stage;

    t_cordic_stage r_st [CPR_CORDIC_STEPS+1];
    t_cordic_stage n_st [CPR_CORDIC_STEPS+1];
    logic signed [BW-1:0] r_brg;
    logic signed [BW-1:0] n_brg;

    always_comb begin
        t_cordic_stage cur;
        logic signed [XW-1:0] xx;
        logic signed [XW-1:0] yy;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] ang;

        // Left half plane points are turned by a quarter turn first.
        n_st[0].x    = XW'(i_x);
        n_st[0].y    = XW'(i_y);
        n_st[0].z    = '0;
        n_st[0].zero = (i_x == '0) && (i_y == '0);
        if (i_x[31]) begin
            if (!i_y[31]) begin
                n_st[0].x = XW'(i_y);
                n_st[0].y = -XW'(i_x);
                n_st[0].z = ZW'(CPR_HALF_PI_Q30);
            end else begin
                n_st[0].x = -XW'(i_y);
                n_st[0].y = XW'(i_x);
                n_st[0].z = -ZW'(CPR_HALF_PI_Q30);
            end
        end

        for (int i = 0; i < CPR_CORDIC_STEPS; i++) begin
            cur = r_st[i];
            xx  = cur.x;
            yy  = cur.y;
            dx  = yy >>> i;
            dy  = xx >>> i;
            ang = ZW'(CPR_ATAN[i]);
            n_st[i+1] = cur;
            if (!yy[XW-1] && (yy != '0)) begin
                n_st[i+1].x = xx + dx;
                n_st[i+1].y = yy - dy;
                n_st[i+1].z = cur.z + ang;
            end else begin
                n_st[i+1].x = xx - dx;
                n_st[i+1].y = yy + dy;
                n_st[i+1].z = cur.z - ang;
            end
        end
    end

    always_comb begin
        logic signed [ZW-1:0] zs;
        logic signed [ZW-1:0] zr;

        zs = r_st[CPR_CORDIC_STEPS].z;
        zr = (zs + ZW'(longint'(1) << (SH - 1))) >>> SH;
        if (zr > LIM) begin
            zr = LIM;
        end
        if (zr < -LIM) begin
            zr = -LIM;
        end
        if (r_st[CPR_CORDIC_STEPS].zero) begin
            n_brg = '0;
        end else begin
            n_brg = zr[BW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st  <= n_st;
            r_brg <= n_brg;
        end
    end

    assign o_bearing = r_brg;

endmodule

`default_nettype wire

[rtl/cpr_radial.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpr_radial
    import cpr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [63:0]        i_sq_x,
    input  wire logic [63:0]        i_sq_y,
    input  wire logic [63:0]        i_p1,
    input  wire logic [63:0]        i_p2,
    input  wire logic               i_n1,
    input  wire logic               i_n2,
    input  wire logic [15:0]        i_min,
    output logic [31:0]             o_range,
    output logic signed [31:0]      o_range_rate
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] num;
        logic        neg;
    } t_sqrt_stage;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
        logic [31:0] rng;
        logic        neg;
        logic        ovf;
        logic        zero;
    } t_div_stage;

    t_sqrt_stage r_sq [CPR_SQRT_STEPS+1];
    t_sqrt_stage n_sq [CPR_SQRT_STEPS+1];
    t_div_stage  r_dv [CPR_DIV_STEPS+1];
    t_div_stage  n_dv [CPR_DIV_STEPS+1];

    always_comb begin
        t_sqrt_stage cur;
        logic [63:0] trial;
        logic [63:0] bit_v;

        n_sq[0].rem  = i_sq_x + i_sq_y;
        n_sq[0].root = '0;
        if (i_n1 == i_n2) begin
            n_sq[0].num = i_p1 + i_p2;
            n_sq[0].neg = i_n1;
        end else if (i_p1 >= i_p2) begin
            n_sq[0].num = i_p1 - i_p2;
            n_sq[0].neg = i_n1;
        end else begin
            n_sq[0].num = i_p2 - i_p1;
            n_sq[0].neg = i_n2;
        end

        // One result bit per stage, digit by digit from the top.
        for (int i = 0; i < CPR_SQRT_STEPS; i++) begin
            cur   = r_sq[i];
            bit_v = 64'd1 << (62 - 2 * i);
            trial = cur.root + bit_v;
            n_sq[i+1] = cur;
            if (cur.rem >= trial) begin
                n_sq[i+1].rem  = cur.rem - trial;
                n_sq[i+1].root = (cur.root >> 1) + bit_v;
            end else begin
                n_sq[i+1].root = cur.root >> 1;
            end
        end
    end

    always_comb begin
        t_div_stage  cur;
        logic [31:0] root32;
        logic [31:0] minv;
        logic [32:0] cand;

        root32 = r_sq[CPR_SQRT_STEPS].root[31:0];
        minv   = {16'd0, i_min};
        n_dv[0].rng  = (root32 < minv) ? minv : root32;
        n_dv[0].rem  = r_sq[CPR_SQRT_STEPS].num[63:32];
        n_dv[0].lo   = r_sq[CPR_SQRT_STEPS].num[31:0];
        n_dv[0].q    = '0;
        n_dv[0].neg  = r_sq[CPR_SQRT_STEPS].neg;
        n_dv[0].zero = (n_dv[0].rng == '0);
        // A quotient of 2^32 or more saturates whatever its low bits are.
        n_dv[0].ovf  = (r_sq[CPR_SQRT_STEPS].num[63:32] >= n_dv[0].rng);

        for (int i = 0; i < CPR_DIV_STEPS; i++) begin
            cur  = r_dv[i];
            cand = {cur.rem, cur.lo[31]};
            n_dv[i+1]    = cur;
            n_dv[i+1].lo = cur.lo << 1;
            if (cand >= {1'b0, cur.rng}) begin
                n_dv[i+1].rem = 32'(cand - {1'b0, cur.rng});
                n_dv[i+1].q   = {cur.q[30:0], 1'b1};
            end else begin
                n_dv[i+1].rem = cand[31:0];
                n_dv[i+1].q   = {cur.q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
            r_dv <= n_dv;
        end
    end

    always_comb begin
        t_div_stage  fin;
        logic [31:0] qs;

        fin = r_dv[CPR_DIV_STEPS];
        o_range = fin.rng;
        if (fin.zero) begin
            qs           = '0;
            o_range_rate = '0;
        end else if (fin.neg) begin
            qs = (fin.ovf || (fin.q > 32'h8000_0000)) ? 32'h8000_0000 : fin.q;
            o_range_rate = -qs;
        end else begin
            qs = (fin.ovf || fin.q[31]) ? 32'h7FFF_FFFF : fin.q;
            o_range_rate = qs;
        end
    end

endmodule

`default_nettype wire

[verif/cpr_checker.sv]
`timescale 1ns / 1ps

module cpr_checker
    import cpr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_ready,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic               i_cfg_valid,
    input  wire logic               o_cfg_ready,
    input  wire logic [15:0]        i_min_magnitude,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic [31:0]        o_range,
    input  wire logic signed [18:0] o_bearing,
    input  wire logic signed [31:0] o_range_rate,
    output int                      fail_count,
    output int                      pending_count
);

    typedef struct packed {
        logic [31:0]        range;
        logic signed [18:0] bearing;
        logic signed [31:0] range_rate;
    } polar_t;

    polar_t      polar_q[$];
    logic [15:0] floor_mag;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint cordic_bearing(longint x, longint y);
        longint z, t, dx, dy, lim;
        int sh;
        z = 0;
        sh = 30 - CPR_FRAC_BITS;
        if (x == 0 && y == 0) return 0;
        // Fold the left half plane into the right by a quarter turn.
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = CPR_HALF_PI_Q30;
            end else begin
                x = -y; y = t; z = -CPR_HALF_PI_Q30;
            end
        end
        for (int i = 0; i < CPR_CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(CPR_ATAN[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(CPR_ATAN[i]);
            end
        end
        z = floor_shift(z + (longint'(1) << (sh - 1)), sh);
        lim = floor_shift(CPR_PI_Q30 + (longint'(1) << (sh - 1)), sh);
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return z;
    endfunction

    function automatic polar_t project(longint x, longint y, longint vx, longint vy);
        polar_t p;
        longint unsigned rng, p1, p2, num, q, ax, ay;
        logic n1, n2, neg;
        if ((x < 0 ? -x : x) < longint'(floor_mag)) x = floor_mag;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        rng = int_sqrt(ax * ax + ay * ay);
        if (rng < floor_mag) rng = floor_mag;
        p1 = ax * longint'(vx < 0 ? -vx : vx);
        p2 = ay * longint'(vy < 0 ? -vy : vy);
        n1 = (x < 0) != (vx < 0);
        n2 = (y < 0) != (vy < 0);
        if (n1 == n2) begin
            num = p1 + p2; neg = n1;
        end else if (p1 >= p2) begin
            num = p1 - p2; neg = n1;
        end else begin
            num = p2 - p1; neg = n2;
        end
        q = rng != 0 ? num / rng : 0;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            p.range_rate = 32'(-q);
        end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            p.range_rate = 32'(q);
        end
        p.range = rng[31:0];
        p.bearing = 19'(cordic_bearing(x, y));
        return p;
    endfunction

    assign pending_count = polar_q.size();

    always @(posedge i_clk) begin
        polar_t want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            floor_mag <= CPR_MIN_MAG_RST;
            fail_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) floor_mag <= i_min_magnitude;
            if (i_valid && o_ready)
                polar_q.push_back(project(i_pos_x, i_pos_y, i_vel_x, i_vel_y));
            if (o_valid && i_ready) begin
                if (polar_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    want = polar_q.pop_front();
                    if (want.range !== o_range) begin
                        $error("range: expected %0d, got %0d", want.range, o_range);
                        errs++;
                    end
                    if (want.bearing !== o_bearing) begin
                        $error("bearing: expected %0d, got %0d", want.bearing, o_bearing);
                        errs++;
                    end
                    if (want.range_rate !== o_range_rate) begin
                        $error("range_rate: expected %0d, got %0d",
                               want.range_rate, o_range_rate);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

[verif/tb_cartesian_to_polar_radar_unit.sv]
`timescale 1ns / 1ps

module tb_cartesian_to_polar_radar_unit;
    import cpr_pkg::*;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_ready, i_cfg_valid, o_cfg_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_vel_x, i_vel_y;
    logic [15:0]        i_min_magnitude;
    logic               o_valid, i_ready;
    logic [31:0]        o_range;
    logic signed [18:0] o_bearing;
    logic signed [31:0] o_range_rate;
    int                 fail_count, pending_count;
    bit                 calm;

    cartesian_to_polar_radar_unit uut (.*);

    cpr_checker chk (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_state(logic [31:0] x, y, vx, vy);
        i_valid <= 1;
        i_pos_x <= x; i_pos_y <= y; i_vel_x <= vx; i_vel_y <= vy;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Waits for the pipeline to drain before touching the floor register.
    task automatic set_floor(logic [15:0] v);
        i_valid <= 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (CPR_PIPE_DEPTH + 4) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_min_magnitude <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    // Receiver stalls in random bursts until the final calm stretch.
    initial begin
        i_ready = 1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_ready <= 1;
            end
        end
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [15:0] floors[5];
        int w;
        floors = '{16'd0, 16'd65535, 16'd7, 16'd300, 16'd1};
        calm = 0;
        i_rst_n = 0; i_valid = 0; i_cfg_valid = 0; i_min_magnitude = 0;
        i_pos_x = 0; i_pos_y = 0; i_vel_x = 0; i_vel_y = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed corners at the reset floor, then with a zero floor.
        send_state(0, 0, 5, 5);
        send_state(3, 0, 32'h7FFF_FFFF, 0);
        send_state(-65536, 0, 1, 1);
        send_state(32'h8000_0000, 0, 32'h8000_0000, 0);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(0, -65536, 0, 32'h8000_0000);
        send_state(-5, 65536, 3, -7);
        set_floor(0);
        send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(-1, 0, 1, 0);
        send_state(1, 1, 32'h8000_0000, 32'h8000_0000);
        send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_state(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);

        for (int ph = 0; ph < 5; ph++) begin
            set_floor(floors[ph]);
            if (ph == 4) calm = 1;
            for (int n = 0; n < 190; n++) begin
                w = $urandom_range(0, 3);
                send_state(pick_coord(), pick_coord(),
                           w == 0 ? pick_coord() : $urandom, $urandom);
            end
        end
        i_valid <= 0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (CPR_PIPE_DEPTH + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/cpr_pkg.sv
rtl/cpr_cordic.sv
rtl/cpr_radial.sv
rtl/cartesian_to_polar_radar_unit.sv
verif/cpr_checker.sv
verif/tb_cartesian_to_polar_radar_unit.sv
